// File: rtl/serial_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared property shapes for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial frame receiver check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial frame receiver check failed");

`endif

// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Result kind codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_MAX_LENGTH    = 2'd0;
  localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_EDGE_TIMEOUT  = 2'd2;

  localparam logic [7:0]  MAX_LENGTH_RST    = 8'd255;
  localparam logic [19:0] FIRST_TIMEOUT_RST = 20'd100000;
  localparam logic [15:0] EDGE_TIMEOUT_RST  = 16'd20;

endpackage

// File: rtl/serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Serial frame receiver
// Length-prefixed frame receiver for a two-wire clocked serial link.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample tick per item (start strobe, clock wire, data wire).
//           A start item arms a new frame and aborts any frame in progress.
//   out_* : at most one result per tick: payload byte with its index, frame
//           end without byte, or clock timeout. frame_done marks the last one.
//   cfg_* : register writes (max length, first-bit and edge timeouts), always
//           ready; write only while no frame is being received.
// Timing: a result is registered and appears on out_* in the cycle after the tick that causes it.
// Throughput: one item per cycle while in_ready is high; the tick is decoded
//   in one pass of logic between the state registers and the output register.
// Stall: the output register holds a result until taken; a new item is taken
//   in the same cycle the held result leaves, so in_ready only drops while a
//   result sits unaccepted.
// Reset: synchronous, active low; receiver goes idle, registers return to
//   255 / 100000 / 20 and no result is held.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic        in_clock_line,
  input  logic        in_data_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [7:0]  out_index,
  output logic        out_frame_done,
  output logic [7:0]  out_stored_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_LOW,
    PH_WAIT_HIGH
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic        length_pending_r, length_pending_nxt;
  logic        first_wait_r, first_wait_nxt;
  logic [19:0] wait_ticks_r, wait_ticks_nxt;

  logic [7:0]  max_length_r;
  logic [19:0] first_timeout_r;
  logic [15:0] edge_timeout_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_value_r;
  logic [7:0]  out_index_r;
  logic        out_frame_done_r;
  logic [7:0]  out_stored_count_r;

  logic        in_fire;
  logic [19:0] wait_inc;
  logic [19:0] low_limit;
  logic [7:0]  full_byte;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_value;
  logic [7:0]  res_index;
  logic        res_done;
  logic [7:0]  res_stored;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign wait_inc  = wait_ticks_r + 20'd1;
  assign low_limit = first_wait_r ? first_timeout_r : {4'd0, edge_timeout_r};
  assign full_byte = {shift_byte_r[6:0], in_data_line};

  always_comb begin
    phase_nxt          = phase_r;
    bit_count_nxt      = bit_count_r;
    shift_byte_nxt     = shift_byte_r;
    frame_length_nxt   = frame_length_r;
    byte_count_nxt     = byte_count_r;
    length_pending_nxt = length_pending_r;
    first_wait_nxt     = first_wait_r;
    wait_ticks_nxt     = wait_ticks_r;
    res_valid          = 1'b0;
    res_kind           = KIND_END;
    res_value          = 8'd0;
    res_index          = 8'd0;
    res_done           = 1'b0;

    if (in_fire) begin
      if (in_start_req) begin
        phase_nxt          = PH_WAIT_LOW;
        bit_count_nxt      = 3'd0;
        shift_byte_nxt     = 8'd0;
        frame_length_nxt   = 8'd0;
        byte_count_nxt     = 8'd0;
        length_pending_nxt = 1'b1;
        first_wait_nxt     = 1'b1;
        wait_ticks_nxt     = 20'd0;
      end else begin
        unique case (phase_r)
          PH_WAIT_LOW: begin
            if (!in_clock_line) begin
              shift_byte_nxt = full_byte;
              first_wait_nxt = 1'b0;
              wait_ticks_nxt = 20'd0;
              phase_nxt      = PH_WAIT_HIGH;
            end else begin
              wait_ticks_nxt = wait_inc;
              if (wait_inc >= low_limit) begin
                res_valid = 1'b1;
                res_kind  = KIND_TIMEOUT;
                res_done  = 1'b1;
              end
            end
          end
          PH_WAIT_HIGH: begin
            if (in_clock_line) begin
              wait_ticks_nxt = 20'd0;
              phase_nxt      = PH_WAIT_LOW;
              bit_count_nxt  = bit_count_r + 3'd1;
              if (bit_count_r == 3'd7) begin
                shift_byte_nxt = 8'd0;
                if (length_pending_r) begin
                  length_pending_nxt = 1'b0;
                  frame_length_nxt   = shift_byte_r;
                  if (shift_byte_r == 8'd0) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_END;
                    res_done  = 1'b1;
                  end
                end else begin
                  byte_count_nxt = byte_count_r + 8'd1;
                  if (byte_count_r < max_length_r) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_BYTE;
                    res_value = shift_byte_r;
                    res_index = byte_count_r;
                    res_done  = (byte_count_nxt == frame_length_r);
                  end else if (byte_count_nxt == frame_length_r) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_END;
                    res_done  = 1'b1;
                  end
                end
              end
            end else begin
              wait_ticks_nxt = wait_inc;
              if (wait_inc >= {4'd0, edge_timeout_r}) begin
                res_valid = 1'b1;
                res_kind  = KIND_TIMEOUT;
                res_done  = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (res_done) begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  assign res_stored = (byte_count_nxt < max_length_r) ? byte_count_nxt : max_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      bit_count_r      <= 3'd0;
      shift_byte_r     <= 8'd0;
      frame_length_r   <= 8'd0;
      byte_count_r     <= 8'd0;
      length_pending_r <= 1'b1;
      first_wait_r     <= 1'b1;
      wait_ticks_r     <= 20'd0;
      max_length_r     <= MAX_LENGTH_RST;
      first_timeout_r  <= FIRST_TIMEOUT_RST;
      edge_timeout_r   <= EDGE_TIMEOUT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      bit_count_r      <= bit_count_nxt;
      shift_byte_r     <= shift_byte_nxt;
      frame_length_r   <= frame_length_nxt;
      byte_count_r     <= byte_count_nxt;
      length_pending_r <= length_pending_nxt;
      first_wait_r     <= first_wait_nxt;
      wait_ticks_r     <= wait_ticks_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_LENGTH:    max_length_r    <= cfg_data[7:0];
          REG_FIRST_TIMEOUT: first_timeout_r <= cfg_data;
          REG_EDGE_TIMEOUT:  edge_timeout_r  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        out_valid_r <= res_valid;
      end
      if (res_valid) begin
        out_kind_r         <= res_kind;
        out_value_r        <= res_value;
        out_index_r        <= res_index;
        out_frame_done_r   <= res_done;
        out_stored_count_r <= res_stored;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_index        = out_index_r;
  assign out_frame_done   = out_frame_done_r;
  assign out_stored_count = out_stored_count_r;

endmodule

// File: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// Serial frame receiver port checker
// Watches the result channel of the receiver; bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_unit_assert.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic [7:0] out_index,
  input logic       out_frame_done,
  input logic [7:0] out_stored_count
);

  logic [17:0] held_fields;
  logic        not_byte;
  logic        frame_end;

  assign held_fields = {out_kind, out_value, out_index};
  assign not_byte    = (out_kind != KIND_BYTE);
  assign frame_end   = (out_kind == KIND_END) || (out_kind == KIND_TIMEOUT);

  `SFR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(held_fields))

  `SFR_ASSERT_NOW(a_non_byte_zero, out_valid && not_byte, out_value == 8'd0 && out_index == 8'd0)

  `SFR_ASSERT_NOW(a_end_is_done, out_valid && frame_end, out_frame_done)

  `SFR_ASSERT_NOW(a_byte_count, out_valid && !not_byte, out_stored_count == out_index + 8'd1)

endmodule

bind serial_frame_receiver_unit sfr_checker u_sfr_checker (.*);

// File: test/serial_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Drives sample ticks of the clock and data wires into the receiver, keeps a
// cycle-free model of the frame decoder and checks every result against it,
// across several register settings and idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit_tb;
  import sfr_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_TICKS = 900;
  localparam int PHASES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    RX_IDLE      = 2'd0,
    RX_WAIT_LOW  = 2'd1,
    RX_WAIT_HIGH = 2'd2
  } rx_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] index;
    logic       frame_done;
    logic [7:0] stored_count;
  } rx_result_t;

  class frame_predictor;
    logic [7:0]  max_len = MAX_LENGTH_RST;
    logic [19:0] first_to = FIRST_TIMEOUT_RST;
    logic [15:0] edge_to = EDGE_TIMEOUT_RST;
    rx_phase_t   phase = RX_IDLE;
    logic [2:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  frame_len = '0;
    logic [7:0]  byte_cnt = '0;
    bit          len_pending = 1'b1;
    bit          first_wait = 1'b1;
    logic [19:0] wait_cnt = '0;
    rx_result_t  expected_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          ticks_seen = 0;
    int          kind_cnt[4] = '{0, 0, 0, 0};

    function void write_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        REG_MAX_LENGTH:    max_len = data[7:0];
        REG_FIRST_TIMEOUT: first_to = data;
        REG_EDGE_TIMEOUT:  edge_to = data[15:0];
        default: ;
      endcase
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] value, logic [7:0] idx, bit done);
      rx_result_t r;
      r.kind = kind;
      r.value = value;
      r.index = idx;
      r.frame_done = done;
      r.stored_count = (byte_cnt < max_len) ? byte_cnt : max_len;
      expected_q.push_back(r);
      if (done) phase = RX_IDLE;
    endfunction

    function void count_wait(logic [19:0] limit);
      wait_cnt = wait_cnt + 20'd1;
      if (wait_cnt >= limit) add_result(KIND_TIMEOUT, 8'd0, 8'd0, 1'b1);
    endfunction

    function void close_byte();
      logic [7:0] b;
      logic [7:0] idx;
      bit last;
      b = shreg;
      shreg = '0;
      if (len_pending) begin
        len_pending = 1'b0;
        frame_len = b;
        if (frame_len == 8'd0) add_result(KIND_END, 8'd0, 8'd0, 1'b1);
        return;
      end
      idx = byte_cnt;
      byte_cnt = byte_cnt + 8'd1;
      last = (byte_cnt == frame_len);
      if (idx < max_len) add_result(KIND_BYTE, b, idx, last);
      else if (last) add_result(KIND_END, 8'd0, 8'd0, 1'b1);
    endfunction

    function void note_tick(bit start, bit clk_l, bit dat);
      ticks_seen++;
      if (start) begin
        phase = RX_WAIT_LOW;
        bit_cnt = '0;
        shreg = '0;
        frame_len = '0;
        byte_cnt = '0;
        len_pending = 1'b1;
        first_wait = 1'b1;
        wait_cnt = '0;
        return;
      end
      case (phase)
        RX_WAIT_LOW: begin
          if (!clk_l) begin
            shreg = {shreg[6:0], dat};
            first_wait = 1'b0;
            wait_cnt = '0;
            phase = RX_WAIT_HIGH;
          end else begin
            count_wait(first_wait ? first_to : {4'd0, edge_to});
          end
        end
        RX_WAIT_HIGH: begin
          if (clk_l) begin
            wait_cnt = '0;
            phase = RX_WAIT_LOW;
            bit_cnt = bit_cnt + 3'd1;
            if (bit_cnt == 3'd0) close_byte();
          end else begin
            count_wait({4'd0, edge_to});
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d value %0d index %0d done %0b count %0d",
                   $time, got.kind, got.value, got.index, got.frame_done, got.stored_count);
        return;
      end
      want = expected_q.pop_front();
      kind_cnt[want.kind]++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp kind %0d val %0d idx %0d done %0b cnt %0d, got %0d %0d %0d %0b %0d",
                   $time, want.kind, want.value, want.index, want.frame_done,
                   want.stored_count, got.kind, got.value, got.index, got.frame_done,
                   got.stored_count);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_start_req = 1'b0;
  logic        in_clock_line = 1'b1;
  logic        in_data_line = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [7:0]  out_index;
  logic        out_frame_done;
  logic [7:0]  out_stored_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  frame_predictor sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int ticks_sent = 0;
  int lim_first = int'(FIRST_TIMEOUT_RST);
  int lim_edge = int'(EDGE_TIMEOUT_RST);

  serial_frame_receiver_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_req     (in_start_req),
    .in_clock_line    (in_clock_line),
    .in_data_line     (in_data_line),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_index        (out_index),
    .out_frame_done   (out_frame_done),
    .out_stored_count (out_stored_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // results checked before the new item is noted
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n && sb != null) begin
      if (out_valid && out_ready)
        sb.check_result({out_kind, out_value, out_index, out_frame_done, out_stored_count});
      if (in_valid && in_ready) sb.note_tick(in_start_req, in_clock_line, in_data_line);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("run stopped after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input bit start, input bit clk_l, input bit dat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_clock_line <= clk_l;
    in_data_line <= dat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] ml, input logic [19:0] ft,
                            input logic [15:0] et, input bit poke_spare);
    logic [1:0]  idx_list[4];
    logic [19:0] val_list[4];
    int n;
    int k;
    idx_list[0] = REG_MAX_LENGTH;
    idx_list[1] = REG_FIRST_TIMEOUT;
    idx_list[2] = REG_EDGE_TIMEOUT;
    idx_list[3] = REG_SPARE;
    val_list[0] = {12'd0, ml};
    val_list[1] = ft;
    val_list[2] = {4'd0, et};
    val_list[3] = 20'($urandom_range(20'hFFFFF));
    n = poke_spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data <= val_list[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    lim_first = int'(ft);
    lim_edge = int'(et);
  endtask

  // waits kept below the timeout in force
  task automatic send_bit(input bit d, input bit first);
    int lim;
    int hi;
    int lo;
    lim = first ? lim_first : lim_edge;
    hi = ($urandom_range(99) < 70) ? 0 : $urandom_range((lim - 1 < 2) ? lim - 1 : 2);
    lo = ($urandom_range(99) < 70) ? 0 : $urandom_range((lim_edge - 1 < 2) ? lim_edge - 1 : 2);
    repeat (hi) send_tick(1'b0, 1'b1, 1'($urandom_range(1)));
    send_tick(1'b0, 1'b0, d);
    repeat (lo) send_tick(1'b0, 1'b0, 1'($urandom_range(1)));
    send_tick(1'b0, 1'b1, 1'($urandom_range(1)));
  endtask

  task automatic send_byte(input logic [7:0] b, input bit first);
    int i;
    for (i = 7; i >= 0; i--) send_bit(b[i], first && i == 7);
  endtask

  task automatic send_frame(input int len, input int n_bytes);
    send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    send_byte(len[7:0], 1'b1);
    repeat (n_bytes) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // frame cut short; if the timeout in force is at most 64, the clock then stalls high or low until it times out
  task automatic broken_frame();
    int nbits;
    int lim;
    int i;
    send_tick(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    nbits = $urandom_range(20);
    for (i = 0; i < nbits; i++) send_bit(1'($urandom_range(1)), i == 0);
    if ($urandom_range(1)) begin
      lim = lim_edge;
      if (lim <= 64) begin
        send_tick(1'b0, 1'b0, 1'($urandom_range(1)));
        repeat (lim) send_tick(1'b0, 1'b0, 1'($urandom_range(1)));
      end
    end else begin
      lim = (nbits == 0) ? lim_first : lim_edge;
      if (lim <= 64) repeat (lim) send_tick(1'b0, 1'b1, 1'($urandom_range(1)));
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(20, 5))
      send_tick($urandom_range(15) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 75) return $urandom_range(4, 1);
    if (r < 95) return $urandom_range(10, 5);
    return $urandom_range(24, 11);
  endfunction

  task automatic run_phase(input int p);
    logic [7:0]  ml;
    logic [19:0] ft;
    logic [15:0] et;
    int target;
    int r;
    int len;
    case (p)
      0: begin ml = 8'd255; ft = 20'hFFFFF; et = 16'hFFFF; end
      1: begin ml = 8'd0;   ft = 20'd1;     et = 16'd1;    end
      2: begin ml = 8'd2;   ft = 20'd10;    et = 16'd3;    end
      3: begin ml = 8'd1;   ft = 20'd5;     et = 16'd8;    end
      4: begin ml = 8'd255; ft = 20'd30;    et = 16'd20;   end
      5: begin ml = 8'd3;   ft = 20'd2;     et = 16'd2;    end
      default: begin
        ml = 8'($urandom_range(8));
        ft = 20'($urandom_range(40, 1));
        et = 16'($urandom_range(12, 1));
      end
    endcase
    wait_quiet();
    set_limits(ml, ft, et, p == 0);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
    // long receiver hold-off while frames keep coming
    if (p == 4) hold_asked++;
    target = ticks_sent + RANDOM_TICKS / PHASES;
    while (ticks_sent < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = pick_len();
        send_frame(len, len);
      end else if (r < 85) begin
        broken_frame();
      end else begin
        noise();
      end
    end
    // clean frame so the receiver is idle before the next register writes
    len = $urandom_range(3);
    send_frame(len, len);
  endtask

  initial begin : stimulus
    int p;
    sb = new;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks with nothing armed, then a zero-length frame at reset settings
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    repeat (8) begin
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1, 1'b1);
    end
    wait_quiet();
    // clock stuck low after the first sample
    set_limits(MAX_LENGTH_RST, FIRST_TIMEOUT_RST, 16'd2, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);

    for (p = 0; p < PHASES; p++) run_phase(p);

    wait_quiet();
    if (sb.expected_q.size() != 0) begin
      $display("%0d expected results never arrived", sb.expected_q.size());
      sb.mismatches += sb.expected_q.size();
    end
    $display("%0d ticks over %0d register settings, %0d results checked",
             sb.ticks_seen, PHASES + 2, sb.results_seen);
    $display("payload bytes %0d, frame ends %0d, timeouts %0d, mismatches %0d",
             sb.kind_cnt[KIND_BYTE], sb.kind_cnt[KIND_END], sb.kind_cnt[KIND_TIMEOUT],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: serial_frame_receiver_unit.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/serial_frame_receiver_unit.sv
rtl/sfr_checker.sv
test/serial_frame_receiver_unit_tb.sv
